// ===== design/fsbrs_pkg.sv =====
// ----------------------------------------------------------------------------
// fsbrs_pkg
// Types and codes shared by the frame store core, its checker and the bench.
// ----------------------------------------------------------------------------
package fsbrs_pkg;

   localparam int PANEL_SIZE_DEF = 64;

   // Request kinds
   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_BLEND = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;
   localparam logic [1:0] REQ_SCAN  = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_ROTATION   = 2'd0;
   localparam logic [1:0] CSR_RED_GAIN   = 2'd1;
   localparam logic [1:0] CSR_GREEN_GAIN = 2'd2;
   localparam logic [1:0] CSR_BLUE_GAIN  = 2'd3;

   // Rotation codes, clockwise
   localparam logic [1:0] ROT_0   = 2'd0;
   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   localparam logic [6:0] GAIN_MAX     = 7'd100;
   localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
   localparam logic [7:0] ALPHA_CLEAR  = 8'd0;

   // v / 100 == (v * 5243) >> 19 for every v up to 255 * 100 + 50.
   localparam logic [15:0] DIV100_RECIP = 16'd5243;
   localparam int          DIV100_SHIFT = 19;

   typedef struct packed {
      logic [1:0]        req_type;
      logic signed [7:0] xpos;
      logic signed [7:0] ypos;
      logic [7:0]        red;
      logic [7:0]        green;
      logic [7:0]        blue;
      logic [7:0]        alpha;
   } fsbrs_req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
   } fsbrs_rsp_type;

endpackage

// ===== design/frame_store_blend_rotate_scan_core.sv =====
// ----------------------------------------------------------------------------
// frame_store_blend_rotate_scan_core
// Square RGB frame store with write, alpha blend, read and rotated scan-out.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel (valid/ready) carries write, blend, read and scan
//   requests. Reads and scans return one pixel on the rsp channel
//   (valid/ready); writes and blends return nothing. Out-of-panel writes and
//   blends are dropped, out-of-panel reads and scans return black.
//   The csr port sets rotation and per-channel scan gain; write it only
//   while no request is in flight.
// Sequence:
//   A write, an ignored blend, or a blend with alpha 0 or 255 is done in
//   the idle state. A blend that mixes steps through store read, multiply,
//   then divide and write back through the one write port of the pixel
//   memory. A read or scan steps through the same states, then an output
//   state that loads its result into the output register. Requests are
//   worked one at a time; the pixel memory read-modify-write sets the pace.
// Reset and stall:
//   Reset clears the control state and sets rotation 0 and gains to 100.
//   The pixel memory is not cleared. A result waits in the output register;
//   a further write or blend is still accepted meanwhile, and a further read
//   or scan holds in its last step until the output register is free.
// ----------------------------------------------------------------------------
module frame_store_blend_rotate_scan_core
   import fsbrs_pkg::*;
#(
   parameter int PanelSize = PANEL_SIZE_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  fsbrs_req_type req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output fsbrs_rsp_type rsp_data,
   input  logic          csr_write_en,
   input  logic [1:0]    csr_index,
   input  logic [6:0]    csr_wdata
);

   localparam int Depth = PanelSize * PanelSize;
   localparam int AW    = $clog2(Depth);
   localparam int CW    = $clog2(PanelSize);
   localparam logic signed [8:0] PanelLimit = 9'(PanelSize);
   localparam logic [CW-1:0]     CoordMax   = CW'(PanelSize - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [23:0] mem [Depth];

   logic [1:0]    state_ff, state_in;
   logic [1:0]    rotation_ff;
   logic [6:0]    gain_ff [3];
   logic [1:0]    kind_ff;
   logic          hit_ff;
   logic [AW-1:0] addr_ff;
   logic [23:0]   color_ff;
   logic [7:0]    alpha_ff;
   logic [23:0]   rd_data_ff;
   logic [15:0]   mix_ff [3];
   logic [15:0]   mix_in [3];
   logic [7:0]    res_ff [3];
   logic [7:0]    res_in [3];
   logic          rsp_valid_ff, rsp_valid_in;
   fsbrs_rsp_type rsp_data_ff;

   logic signed [8:0]  xs, ys;
   logic               in_panel;
   logic [CW-1:0]      xc, yc, lx, ly;
   logic [AW-1:0]      addr;
   logic               req_accept;
   logic               wr_direct;
   logic               needs_mix;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [23:0]        mem_wdata;
   logic [7:0]         blend_q [3];
   logic [6:0]         gain_lim [3];
   logic signed [8:0]  diff [3];
   logic signed [17:0] prod [3];
   logic signed [17:0] acc [3];
   logic [15:0]        div255 [3];
   logic [28:0]        q100 [3];
   logic               rsp_load;

   // Coordinate check and address mapping
   always_comb begin
      xs       = {req_data.xpos[7], req_data.xpos};
      ys       = {req_data.ypos[7], req_data.ypos};
      in_panel = !xs[8] && !ys[8] && (xs < PanelLimit) && (ys < PanelLimit);
      xc       = req_data.xpos[CW-1:0];
      yc       = req_data.ypos[CW-1:0];
      lx       = xc;
      ly       = yc;
      if (req_data.req_type == REQ_SCAN) begin
         case (rotation_ff)
            ROT_90: begin
               lx = yc;
               ly = CoordMax - xc;
            end
            ROT_180: begin
               lx = CoordMax - xc;
               ly = CoordMax - yc;
            end
            ROT_270: begin
               lx = CoordMax - yc;
               ly = xc;
            end
            default: begin
               lx = xc;
               ly = yc;
            end
         endcase
      end
      addr = AW'(AW'(ly) * AW'(PanelSize)) + AW'(lx);
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;

   // Opaque blends store the color directly, like writes.
   assign wr_direct = req_accept && in_panel &&
                      ((req_data.req_type == REQ_WRITE) ||
                       ((req_data.req_type == REQ_BLEND) &&
                        (req_data.alpha == ALPHA_OPAQUE)));
   assign needs_mix = in_panel && (req_data.req_type == REQ_BLEND) &&
                      (req_data.alpha != ALPHA_OPAQUE) &&
                      (req_data.alpha != ALPHA_CLEAR);

   // Per-channel datapath; channel 0 is blue, 2 is red.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         gain_lim[i] = (gain_ff[i] > GAIN_MAX) ? GAIN_MAX : gain_ff[i];
         // old*(255-a) + new*a == old*255 + (new-old)*a
         diff[i] = $signed({1'b0, color_ff[8*i +: 8]}) -
                   $signed({1'b0, rd_data_ff[8*i +: 8]});
         prod[i] = diff[i] * $signed({1'b0, alpha_ff});
         acc[i]  = $signed({2'b00, rd_data_ff[8*i +: 8], 8'h00}) -
                   $signed({10'd0, rd_data_ff[8*i +: 8]}) + prod[i] + 18'sd127;
         case (kind_ff)
            REQ_BLEND: mix_in[i] = 16'(acc[i]);
            REQ_SCAN:  mix_in[i] = 16'(16'(rd_data_ff[8*i +: 8]) * 16'(gain_lim[i]))
                                   + 16'd50;
            default:   mix_in[i] = 16'(rd_data_ff[8*i +: 8]);
         endcase
         // x / 255 == (x + (x >> 8) + 1) >> 8 over the blend range.
         div255[i]  = mix_ff[i] + (mix_ff[i] >> 8) + 16'd1;
         blend_q[i] = div255[i][15:8];
         q100[i]    = 29'(mix_ff[i]) * 29'(DIV100_RECIP);
         if (!hit_ff) begin
            res_in[i] = 8'd0;
         end else if (kind_ff == REQ_SCAN) begin
            res_in[i] = q100[i][DIV100_SHIFT +: 8];
         end else begin
            res_in[i] = mix_ff[i][7:0];
         end
      end
   end

   assign rsp_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (needs_mix || (req_data.req_type == REQ_READ) ||
                               (req_data.req_type == REQ_SCAN))) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_DIV;
         ST_DIV:  state_in = (kind_ff == REQ_BLEND) ? ST_IDLE : ST_OUT;
         ST_OUT:  state_in = rsp_load ? ST_IDLE : ST_OUT;
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   // Single write port shared by direct stores and blend write-back.
   always_comb begin
      mem_we    = wr_direct || ((state_ff == ST_DIV) && (kind_ff == REQ_BLEND));
      mem_waddr = wr_direct ? addr : addr_ff;
      mem_wdata = wr_direct ? {req_data.red, req_data.green, req_data.blue}
                            : {blend_q[2], blend_q[1], blend_q[0]};
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (req_accept) begin
         rd_data_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rotation_ff  <= ROT_0;
         gain_ff[0]   <= GAIN_MAX;
         gain_ff[1]   <= GAIN_MAX;
         gain_ff[2]   <= GAIN_MAX;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_ROTATION:   rotation_ff <= csr_wdata[1:0];
               CSR_RED_GAIN:   gain_ff[2]  <= csr_wdata;
               CSR_GREEN_GAIN: gain_ff[1]  <= csr_wdata;
               CSR_BLUE_GAIN:  gain_ff[0]  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff  <= req_data.req_type;
         hit_ff   <= in_panel;
         addr_ff  <= addr;
         color_ff <= {req_data.red, req_data.green, req_data.blue};
         alpha_ff <= req_data.alpha;
      end
      if (state_ff == ST_MUL) begin
         for (int i = 0; i < 3; i++) begin
            mix_ff[i] <= mix_in[i];
         end
      end
      if (state_ff == ST_DIV) begin
         for (int i = 0; i < 3; i++) begin
            res_ff[i] <= res_in[i];
         end
      end
      if (rsp_load) begin
         rsp_data_ff <= '{out_red: res_ff[2], out_green: res_ff[1], out_blue: res_ff[0]};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/fsbrs_checker.sv =====
// ----------------------------------------------------------------------------
// fsbrs_checker
// Port-level checks on the frame store core, bound into the core module.
// ----------------------------------------------------------------------------
module fsbrs_checker
   import fsbrs_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          req_valid,
   input logic          req_ready,
   input fsbrs_req_type req_data,
   input logic          rsp_valid,
   input logic          rsp_ready,
   input fsbrs_rsp_type rsp_data
);

   // No result is pending right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // A stalled result stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // A read or scan request keeps the block busy in the next cycle.
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      (req_data.req_type == REQ_READ || req_data.req_type == REQ_SCAN)
      |=> !req_ready)
      else $error("ready while a lookup is in flight");

   // A plain write leaves the block ready again in the next cycle.
   a_write_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.req_type == REQ_WRITE) |=> req_ready)
      else $error("write did not complete in one cycle");

   // A result never appears in the cycle right after a request is accepted.
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result appeared too early");

endmodule

bind frame_store_blend_rotate_scan_core fsbrs_checker u_fsbrs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the frame store with blend, read and rotated scan.
// Requests come from a queue filled by the stimulus process and are driven
// on the falling edge. A pixel model predicts every read and scan result at
// acceptance time, and the monitor compares each result with the oldest
// prediction. Random requests only read entries that were already written.
// ----------------------------------------------------------------------------
module tb_top;
   import fsbrs_pkg::*;

   localparam int PANEL       = PANEL_SIZE_DEF;
   localparam int DEPTH       = PANEL * PANEL;
   localparam int NUM_CHUNKS  = 8;
   localparam int CHUNK_ITEMS = 250;
   localparam int IDLE_LIMIT  = 5000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE      = 10;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   fsbrs_req_type req_data = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   fsbrs_rsp_type rsp_data;
   logic          csr_write_en = 1'b0;
   logic [1:0]    csr_index = CSR_ROTATION;
   logic [6:0]    csr_wdata = '0;

   frame_store_blend_rotate_scan_core #(
      .PanelSize(PANEL)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Pixel model and its configuration
   logic [23:0]   pix_model [DEPTH];
   logic [1:0]    model_rotation = ROT_0;
   logic [6:0]    model_gain [3] = '{GAIN_MAX, GAIN_MAX, GAIN_MAX};
   fsbrs_rsp_type pixel_expect_q [$];

   // Stimulus bookkeeping: which entries the queued requests have written
   fsbrs_req_type pending_req_q [$];
   bit            gen_written [DEPTH];
   int            gen_written_q [$];

   int sender_idle_pct = 16;
   int recv_idle_pct   = 60;
   bit hold_armed      = 1'b0;
   bit hold_done       = 1'b0;
   int hold_cnt        = 0;

   int offered_count  = 0;
   int accepted_count = 0;
   int rsp_count      = 0;
   int error_count    = 0;
   int idle_cycles    = 0;
   int kind_count [4] = '{0, 0, 0, 0};

   function automatic logic [7:0] mix_channel(logic [7:0] old_v, logic [7:0] new_v,
                                              logic [7:0] alpha);
      int unsigned acc;
      acc = old_v * (255 - alpha) + new_v * alpha + 127;
      return 8'(acc / 255);
   endfunction

   function automatic logic [7:0] scale_channel(logic [7:0] v, logic [6:0] pct);
      int unsigned p;
      p = (pct > GAIN_MAX) ? GAIN_MAX : pct;
      return 8'((v * p + 50) / 100);
   endfunction

   function automatic bit on_panel(int x, int y);
      return x >= 0 && y >= 0 && x < PANEL && y < PANEL;
   endfunction

   // Updates the pixel model for one accepted request and queues the result of a read or scan.
   task automatic predict_pixel(fsbrs_req_type r);
      int            x;
      int            y;
      int            lx;
      int            ly;
      logic [23:0]   pix;
      fsbrs_rsp_type res;
      x = $signed(r.xpos);
      y = $signed(r.ypos);
      kind_count[r.req_type]++;
      if (r.req_type == REQ_WRITE || r.req_type == REQ_BLEND) begin
         if (on_panel(x, y)) begin
            if (r.req_type == REQ_WRITE || r.alpha == ALPHA_OPAQUE) begin
               pix_model[y * PANEL + x] = {r.red, r.green, r.blue};
            end else if (r.alpha != ALPHA_CLEAR) begin
               pix = pix_model[y * PANEL + x];
               pix_model[y * PANEL + x] = {mix_channel(pix[23:16], r.red, r.alpha),
                                           mix_channel(pix[15:8], r.green, r.alpha),
                                           mix_channel(pix[7:0], r.blue, r.alpha)};
            end
         end
      end else begin
         res = '0;
         if (on_panel(x, y)) begin
            if (r.req_type == REQ_READ) begin
               pix = pix_model[y * PANEL + x];
               res = {pix[23:16], pix[15:8], pix[7:0]};
            end else begin
               case (model_rotation)
                  ROT_90: begin
                     lx = y;
                     ly = PANEL - 1 - x;
                  end
                  ROT_180: begin
                     lx = PANEL - 1 - x;
                     ly = PANEL - 1 - y;
                  end
                  ROT_270: begin
                     lx = PANEL - 1 - y;
                     ly = x;
                  end
                  default: begin
                     lx = x;
                     ly = y;
                  end
               endcase
               pix = pix_model[ly * PANEL + lx];
               res.out_red   = scale_channel(pix[23:16], model_gain[0]);
               res.out_green = scale_channel(pix[15:8], model_gain[1]);
               res.out_blue  = scale_channel(pix[7:0], model_gain[2]);
            end
         end
         pixel_expect_q.push_back(res);
      end
   endtask

   // Driver: holds a request until it is taken, then maybe offers the next.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && accepted_count != offered_count)) begin
         if (pending_req_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_data  <= pending_req_q.pop_front();
            req_valid <= 1'b1;
            offered_count++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off when armed.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_armed && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_cnt++;
         if (hold_cnt >= HOLD_CYCLES) begin
            hold_done = 1'b1;
         end
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: checks results, predicts accepted requests, guards progress.
   always @(posedge clock) begin
      fsbrs_rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (pixel_expect_q.size() == 0) begin
               $error("unexpected result %h with no request waiting", rsp_data);
               error_count++;
            end else begin
               want = pixel_expect_q.pop_front();
               if (rsp_data.out_red !== want.out_red) begin
                  $error("out_red mismatch: expected %0d, actual %0d",
                         want.out_red, rsp_data.out_red);
                  error_count++;
               end
               if (rsp_data.out_green !== want.out_green) begin
                  $error("out_green mismatch: expected %0d, actual %0d",
                         want.out_green, rsp_data.out_green);
                  error_count++;
               end
               if (rsp_data.out_blue !== want.out_blue) begin
                  $error("out_blue mismatch: expected %0d, actual %0d",
                         want.out_blue, rsp_data.out_blue);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            accepted_count <= accepted_count + 1;
            predict_pixel(req_data);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no request or result moved for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic queue_request(logic [1:0] kind, int x, int y, logic [7:0] r,
                                logic [7:0] g, logic [7:0] b, logic [7:0] a);
      fsbrs_req_type q;
      q.req_type = kind;
      q.xpos     = x[7:0];
      q.ypos     = y[7:0];
      q.red      = r;
      q.green    = g;
      q.blue     = b;
      q.alpha    = a;
      if (on_panel(x, y) && (kind == REQ_WRITE || (kind == REQ_BLEND && a == ALPHA_OPAQUE))
          && !gen_written[y * PANEL + x]) begin
         gen_written[y * PANEL + x] = 1'b1;
         gen_written_q.push_back(y * PANEL + x);
      end
      pending_req_q.push_back(q);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [6:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_ROTATION:   model_rotation = value[1:0];
         CSR_RED_GAIN:   model_gain[0] = value;
         CSR_GREEN_GAIN: model_gain[1] = value;
         default:        model_gain[2] = value;
      endcase
   endtask

   // Waits until every request is taken and every result has come back, then
   // lets a blend still in its read-modify-write finish.
   task automatic wait_idle();
      while (pending_req_q.size() != 0 || offered_count != accepted_count
             || pixel_expect_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_channel();
      int sel;
      sel = $urandom_range(9);
      if (sel == 0) return 8'd0;
      if (sel == 1) return 8'd255;
      return 8'($urandom_range(255));
   endfunction

   function automatic int off_panel_coord();
      if ($urandom_range(1)) return -int'($urandom_range(128, 1));
      return int'($urandom_range(127, PANEL));
   endfunction

   task automatic queue_random_chunk(int count, logic [1:0] rot);
      int         n;
      int         sel;
      int         kind;
      int         x;
      int         y;
      int         lx;
      int         ly;
      int         idx;
      logic [7:0] a;
      for (n = 0; n < count; n++) begin
         sel = $urandom_range(99);
         kind = (sel < 30) ? REQ_WRITE : (sel < 55) ? REQ_BLEND :
                (sel < 75) ? REQ_READ : REQ_SCAN;
         sel = $urandom_range(9);
         a = (sel == 0) ? ALPHA_CLEAR : (sel == 1) ? ALPHA_OPAQUE : 8'($urandom_range(255));
         if ($urandom_range(99) < 8) begin
            // Off-panel request of any kind, either coordinate out of range.
            if ($urandom_range(1)) begin
               x = off_panel_coord();
               y = int'($urandom_range(255)) - 128;
            end else begin
               x = int'($urandom_range(255)) - 128;
               y = off_panel_coord();
            end
         end else begin
            if (gen_written_q.size() == 0 && kind != REQ_WRITE) begin
               kind = REQ_WRITE;
            end
            if (kind == REQ_WRITE || (kind == REQ_BLEND && a == ALPHA_OPAQUE)) begin
               x = $urandom_range(PANEL - 1);
               y = $urandom_range(PANEL - 1);
            end else begin
               idx = gen_written_q[$urandom_range(gen_written_q.size() - 1)];
               lx = idx % PANEL;
               ly = idx / PANEL;
               x = lx;
               y = ly;
               if (kind == REQ_SCAN) begin
                  case (rot)
                     ROT_90: begin
                        x = PANEL - 1 - ly;
                        y = lx;
                     end
                     ROT_180: begin
                        x = PANEL - 1 - lx;
                        y = PANEL - 1 - ly;
                     end
                     ROT_270: begin
                        x = ly;
                        y = PANEL - 1 - lx;
                     end
                     default: ;
                  endcase
               end
            end
         end
         queue_request(2'(kind), x, y, pick_channel(), pick_channel(), pick_channel(), a);
      end
   endtask

   initial begin
      int         c;
      logic [1:0] rot;
      logic [6:0] gains [3];
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed requests under the reset configuration.
      queue_request(REQ_WRITE, 0, 0, 8'hff, 8'hff, 8'hff, 8'h00);
      queue_request(REQ_WRITE, 63, 63, 8'h00, 8'h00, 8'h00, 8'hff);
      queue_request(REQ_WRITE, 63, 0, 8'h12, 8'h34, 8'h56, 8'h80);
      queue_request(REQ_WRITE, 0, 63, 8'hab, 8'hcd, 8'hef, 8'h01);
      queue_request(REQ_WRITE, -128, -128, 8'h55, 8'haa, 8'h55, 8'h00);
      queue_request(REQ_WRITE, 64, 127, 8'haa, 8'h55, 8'haa, 8'hff);
      queue_request(REQ_BLEND, 0, 0, 8'h00, 8'h00, 8'h00, ALPHA_CLEAR);
      queue_request(REQ_BLEND, 63, 63, 8'h80, 8'h90, 8'ha0, ALPHA_OPAQUE);
      queue_request(REQ_BLEND, 63, 0, 8'hff, 8'h00, 8'h80, 8'd128);
      queue_request(REQ_BLEND, -1, 5, 8'h11, 8'h22, 8'h33, 8'd100);
      queue_request(REQ_BLEND, 0, 63, 8'h00, 8'h00, 8'h00, 8'd1);
      queue_request(REQ_BLEND, 0, 0, 8'h00, 8'hff, 8'h00, 8'd254);
      queue_request(REQ_READ, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_request(REQ_READ, 63, 63, 8'hff, 8'hff, 8'hff, 8'hff);
      queue_request(REQ_READ, 63, 0, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_request(REQ_READ, 0, 63, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_request(REQ_READ, -1, 0, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_request(REQ_READ, 0, 64, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_request(REQ_READ, 127, -128, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_request(REQ_SCAN, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_request(REQ_SCAN, 63, 63, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_request(REQ_SCAN, 63, 0, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_request(REQ_SCAN, 64, 0, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_request(REQ_SCAN, -128, 127, 8'h00, 8'h00, 8'h00, 8'h00);
      wait_idle();

      for (c = 0; c < NUM_CHUNKS; c++) begin
         case (c)
            0: begin
               rot = ROT_0;
               gains = '{GAIN_MAX, GAIN_MAX, GAIN_MAX};
            end
            1: begin
               rot = ROT_90;
               gains = '{7'd0, 7'd0, 7'd0};
            end
            2: begin
               rot = ROT_180;
               gains = '{7'd127, 7'd101, 7'd50};
            end
            3: begin
               rot = ROT_270;
               gains = '{7'd1, 7'd99, 7'd127};
            end
            default: begin
               rot = 2'($urandom_range(3));
               gains = '{7'($urandom_range(127)), 7'($urandom_range(127)),
                         7'($urandom_range(127))};
            end
         endcase
         if (c == 3) begin
            sender_idle_pct = 60;
            recv_idle_pct   = 16;
         end else if (c == 6) begin
            sender_idle_pct = 0;
            recv_idle_pct   = 0;
            hold_armed      = 1'b1;
         end
         write_csr(CSR_ROTATION, {5'd0, rot});
         write_csr(CSR_RED_GAIN, gains[0]);
         write_csr(CSR_GREEN_GAIN, gains[1]);
         write_csr(CSR_BLUE_GAIN, gains[2]);
         queue_random_chunk(CHUNK_ITEMS, rot);
         wait_idle();
      end

      if (pixel_expect_q.size() != 0) begin
         $error("%0d predicted results never arrived", pixel_expect_q.size());
         error_count++;
      end
      $display("Covered %0d requests: %0d writes, %0d blends, %0d reads, %0d scans; %0d results",
               accepted_count, kind_count[REQ_WRITE], kind_count[REQ_BLEND],
               kind_count[REQ_READ], kind_count[REQ_SCAN], rsp_count);
      $display("Settings spanned all four rotations, gains 0 to 127, and three stall patterns.");
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
